// ===== design/rdsm_pkg.sv =====
// Package: constants, types and helpers shared by the regex dot-star matcher.
`timescale 1ns / 1ps
package rdsm_pkg;

  localparam int PAT_MAX = 32;
  localparam int PAT_AW  = $clog2(PAT_MAX);
  localparam int LEN_W   = $clog2(PAT_MAX + 1);
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TEXT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SWEEP,
    ST_DONE
  } rdsm_state_t;

  typedef struct packed {
    logic accept;
    logic prime;
    logic step;
    logic load_out;
  } rdsm_cmd_t;

  typedef struct packed {
    logic sweep_go;
    logic last_col;
    logic out_busy;
  } rdsm_sts_t;

  function automatic logic byte_fits(input logic [CHAR_W-1:0] c,
                                     input logic [CHAR_W-1:0] p);
    return (c == p) || (p == CH_DOT);
  endfunction

endpackage

// ===== design/rdsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rdsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/rdsm_ctrl.sv =====
// Controller: sequences accept, row prime, column sweep and result hand-off.
`timescale 1ns / 1ps
module rdsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  rdsm_pkg::rdsm_sts_t  sts,
  output rdsm_pkg::rdsm_cmd_t  cmd
);
  import rdsm_pkg::*;

  rdsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = sts.sweep_go ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.last_col) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/rdsm_dp.sv =====
// Datapath: pattern store, match row, column update and output register.
`timescale 1ns / 1ps
module rdsm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdsm_pkg::rdsm_cmd_t  cmd,
  output rdsm_pkg::rdsm_sts_t  sts,
  input  logic [7:0]           in_tdata,
  input  logic [2:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata
);
  import rdsm_pkg::*;

  logic [1:0]        mode_r;
  logic [CHAR_W-1:0] char_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  col_r;
  logic [PAT_MAX:0]  row_r, row_nxt;
  logic              old_prev_r;
  logic [CHAR_W-1:0] prev_p_r;
  logic              st_r;
  logic              out_valid_r;
  logic              out_match_r;
  logic              out_status_r;

  logic              wr_en;
  logic [PAT_AW-1:0] wr_addr;
  logic [PAT_AW-1:0] rd_addr;
  logic [CHAR_W-1:0] p;
  logic              in_first;
  logic [1:0]        in_mode;
  logic              is_build;
  logic              is_row_mode;
  logic              j_ge2;
  logic              rm2;
  logic              v;

  assign in_mode  = in_tuser[1:0];
  assign in_first = in_tuser[2];

  // store the byte unless the store is full and this load does not restart it
  assign wr_en   = cmd.accept && (in_mode == MODE_LOAD) &&
                   (in_first || (len_r < LEN_W'(PAT_MAX)));
  assign wr_addr = in_first ? '0 : len_r[PAT_AW-1:0];
  assign rd_addr = cmd.prime ? '0 : col_r[PAT_AW-1:0];

  rdsm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (PAT_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (p)
  );

  assign is_build    = (mode_r == MODE_LOAD) || (mode_r == MODE_START);
  assign is_row_mode = is_build || (mode_r == MODE_TEXT);
  assign j_ge2       = col_r >= LEN_W'(2);
  assign rm2         = j_ge2 ? row_r[col_r - LEN_W'(2)] : 1'b0;

  always_comb begin
    v = 1'b0;
    if (is_build) begin
      v = (p == CH_STAR) && rm2;
    end else if (p != CH_STAR) begin
      v = old_prev_r && byte_fits(char_r, p);
    end else if (j_ge2) begin
      v = byte_fits(char_r, prev_p_r) ? (rm2 || row_r[col_r] || old_prev_r) : rm2;
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (cmd.prime && is_row_mode) begin
      row_nxt[0] = is_build;
    end else if (cmd.step) begin
      row_nxt[col_r] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      row_r       <= {{PAT_MAX{1'b0}}, 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        len_r <= LEN_W'(wr_addr) + LEN_W'(1);
      end
      row_r <= row_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      char_r <= in_tdata;
      st_r   <= (in_mode == MODE_LOAD) && !in_first && (len_r >= LEN_W'(PAT_MAX));
    end
    if (cmd.prime) begin
      col_r      <= LEN_W'(1);
      old_prev_r <= row_r[0];
    end else if (cmd.step) begin
      col_r      <= col_r + LEN_W'(1);
      old_prev_r <= row_r[col_r];
      prev_p_r   <= p;
    end
    if (cmd.load_out) begin
      out_match_r  <= ((mode_r == MODE_START) || (mode_r == MODE_TEXT)) && row_r[len_r];
      out_status_r <= st_r;
    end
  end

  assign sts.sweep_go = is_row_mode && (len_r != '0);
  assign sts.last_col = col_r == len_r;
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_match_r};

endmodule

// ===== design/regex_dot_star_matcher_core.sv =====
// Top level of the regex dot-star whole-string matcher.
`timescale 1ns / 1ps
// Usage:
//   Input beats carry a byte in in_tdata and a kind in in_tuser: load a
//   pattern byte ('.' matches any byte, '*' repeats the preceding element),
//   start a new text, or feed one text byte. Set first on a load to clear
//   the stored pattern before appending. Every input beat yields exactly one
//   output beat: match (text so far fully matches the pattern, 0 on loads)
//   and status (pattern store full, byte dropped).
//   Flow: an accepted beat primes the match row, then the sweep visits
//   pattern columns 1..len, where len is the pattern length after the
//   beat (0..32; no sweep for the unused kind), one pattern column per
//   cycle through the single read port of the pattern store; the result
//   then goes to the output register. One item is worked on at a time; a
//   new beat is taken while the previous result still waits at the output.
//   Reset: pattern length clears to zero and the match row to the
//   empty-text state; the pattern store contents are left as they are.
//   A stalled receiver holds the result in the output register and the
//   block waits before handing off the next one.
module regex_dot_star_matcher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_value
  input  logic [2:0] in_tuser,   // [1:0] mode, [2] first
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] match, [1] status, [7:2] zero
);
  import rdsm_pkg::*;

  rdsm_cmd_t cmd;
  rdsm_sts_t sts;

  rdsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdsm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the regex dot-star whole-string matcher.
`timescale 1ns / 1ps
module testbench;
  import rdsm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;  // unused kind: no effect, answers zeros
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_BEATS  = 150;
  localparam int SETTLE_CYCLES = PAT_MAX + 32;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] ch;
    logic       clear_first;
    bit         drain_first;
  } text_beat_t;

  typedef struct {
    logic full_match;
    logic store_full;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  regex_dot_star_matcher_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Matcher state as seen by the predictor
  logic [7:0]       pat_bytes [PAT_MAX];
  int unsigned      pat_len = 0;
  logic [PAT_MAX:0] dp_row = 1;

  text_beat_t pending_beats [$];
  verdict_t   verdicts [$];
  text_beat_t cur_beat;

  int  stim_count = 0;
  int  next_drain_at = 400;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  err_count = 0;
  int  hit_count = 0;
  int  drop_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  cycle_count = 0;
  bit  tail_phase = 1'b0;

  function automatic logic char_ok(logic [7:0] c, logic [7:0] p);
    return (c == p) || (p == CH_DOT);
  endfunction

  function automatic void rebuild_empty_row();
    dp_row = '0;
    dp_row[0] = 1'b1;
    for (int j = 2; j <= PAT_MAX; j++) begin
      if (j <= pat_len && pat_bytes[j-1] == CH_STAR)
        dp_row[j] = dp_row[j-2];
    end
  endfunction

  function automatic logic advance_dp_row(logic [7:0] c);
    logic [PAT_MAX:0] nxt;
    logic [7:0] p;
    nxt = '0;
    for (int j = 1; j <= PAT_MAX; j++) begin
      if (j <= pat_len) begin
        p = pat_bytes[j-1];
        if (p != CH_STAR)
          nxt[j] = dp_row[j-1] && char_ok(c, p);
        else if (j >= 2) begin
          // star column: zero copies, or one more copy of the preceding byte
          if (char_ok(c, pat_bytes[j-2]))
            nxt[j] = nxt[j-2] || dp_row[j] || dp_row[j-1];
          else
            nxt[j] = nxt[j-2];
        end
      end
    end
    dp_row = nxt;
    return dp_row[pat_len];
  endfunction

  function automatic verdict_t predict_verdict(text_beat_t b);
    verdict_t v;
    v.full_match = 1'b0;
    v.store_full = 1'b0;
    case (b.mode)
      MODE_LOAD: begin
        if (b.clear_first) pat_len = 0;
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = b.ch;
          pat_len++;
        end else begin
          v.store_full = 1'b1;
        end
        rebuild_empty_row();
      end
      MODE_START: begin
        rebuild_empty_row();
        v.full_match = dp_row[pat_len];
      end
      MODE_TEXT: v.full_match = advance_dp_row(b.ch);
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_beat(logic [1:0] mode, logic [7:0] ch, logic clear_first);
    text_beat_t b;
    b.mode = mode;
    b.ch = ch;
    b.clear_first = clear_first;
    b.drain_first = (stim_count == next_drain_at);
    if (b.drain_first) next_drain_at += 500;
    pending_beats.push_back(b);
    if (mode != MODE_NONE) stim_count++;
  endtask

  function automatic logic [7:0] pick_pattern_char();
    case ($urandom_range(0, 9))
      0, 1: return "a";
      2, 3: return "b";
      4: return "c";
      5: return CH_DOT;
      6, 7: return CH_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_text_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return "a";
      3, 4: return "b";
      5: return "c";
      6: return CH_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Emit text that walks the generated pattern, so full matches are common
  task automatic add_fitting_text(logic [7:0] pat [$]);
    int i;
    int reps;
    logic [7:0] p;
    i = 0;
    while (i < pat.size()) begin
      p = pat[i];
      if (i + 1 < pat.size() && pat[i+1] == CH_STAR) begin
        reps = $urandom_range(0, 3);
        repeat (reps) add_beat(MODE_TEXT, (p == CH_DOT) ? 8'($urandom_range(0, 255)) : p, 1'b0);
        i += 2;
      end else begin
        add_beat(MODE_TEXT, (p == CH_DOT) ? 8'($urandom_range(0, 255)) : p, 1'b0);
        i++;
      end
    end
  endtask

  task automatic add_pattern_session();
    logic [7:0] gen_pat [$];
    int plen;
    int ntexts;
    int tlen;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 36) : $urandom_range(1, 6);
    for (int k = 0; k < plen; k++) begin
      gen_pat.push_back(pick_pattern_char());
      // occasionally append to the stored pattern instead of clearing it
      add_beat(MODE_LOAD, gen_pat[k], (k == 0) && ($urandom_range(0, 9) != 0));
    end
    ntexts = $urandom_range(1, 3);
    repeat (ntexts) begin
      add_beat(MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) < 6)
        add_fitting_text(gen_pat);
      else begin
        tlen = $urandom_range(0, 8);
        repeat (tlen) add_beat(MODE_TEXT, pick_text_char(), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 19) == 0)
        add_beat(MODE_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Driver: present queued beats, predict each one as it is accepted
  always @(posedge clk) begin
    verdict_t v;
    text_beat_t nb;
    int sent_now;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      sent_now = beats_sent;
      if (in_tvalid && in_tready) begin
        v = predict_verdict(cur_beat);
        verdicts.push_back(v);
        sent_now = beats_sent + 1;
        beats_sent <= sent_now;
      end
      tail_phase <= (pending_beats.size() < TAIL_BEATS);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_beats[0].drain_first && results_seen != sent_now) begin
          // hold until every outstanding result is back
          in_tvalid <= 1'b0;
        end else begin
          nb = pending_beats.pop_front();
          cur_beat = nb;
          in_tdata <= nb.ch;
          in_tuser <= {nb.clear_first, nb.mode};
          in_tvalid <= 1'b1;
          if (pending_beats.size() >= TAIL_BEATS && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 4);
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result beat with nothing expected: actual tdata=%h", $time, out_tdata);
          err_count++;
        end else begin
          want = verdicts.pop_front();
          if (out_tdata[0] !== want.full_match) begin
            $display("%0t: match mismatch: expected %b actual %b",
                     $time, want.full_match, out_tdata[0]);
            err_count++;
          end
          if (out_tdata[1] !== want.store_full) begin
            $display("%0t: status mismatch: expected %b actual %b",
                     $time, want.store_full, out_tdata[1]);
            err_count++;
          end
          if (want.full_match) hit_count++;
          if (want.store_full) drop_count++;
        end
        results_seen <= results_seen + 1;
      end
      if (tail_phase) begin
        out_tready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats queued, %0d results outstanding",
               $time, pending_beats.size(), verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // directed: empty pattern
    add_beat(MODE_START, 8'h00, 1'b0);
    add_beat(MODE_TEXT, 8'h00, 1'b0);
    // leading star never matches
    add_beat(MODE_LOAD, CH_STAR, 1'b1);
    add_beat(MODE_START, 8'hFF, 1'b1);
    add_beat(MODE_TEXT, 8'hFF, 1'b1);
    // star after star compares the literal star byte
    add_beat(MODE_LOAD, "a", 1'b1);
    add_beat(MODE_LOAD, CH_STAR, 1'b0);
    add_beat(MODE_LOAD, CH_STAR, 1'b0);
    add_beat(MODE_START, 8'h00, 1'b0);
    add_beat(MODE_TEXT, "a", 1'b0);
    add_beat(MODE_TEXT, CH_STAR, 1'b0);
    add_beat(MODE_TEXT, CH_STAR, 1'b0);
    // dot-star swallows anything, byte extremes
    add_beat(MODE_LOAD, CH_DOT, 1'b1);
    add_beat(MODE_LOAD, CH_STAR, 1'b0);
    add_beat(MODE_START, 8'h00, 1'b0);
    add_beat(MODE_TEXT, 8'hFF, 1'b0);
    add_beat(MODE_TEXT, 8'h00, 1'b0);
    // unused kind leaves the row alone
    add_beat(MODE_NONE, 8'hFF, 1'b1);
    add_beat(MODE_TEXT, 8'h80, 1'b0);
    add_beat(MODE_LOAD, 8'h00, 1'b1);
    add_beat(MODE_TEXT, 8'h00, 1'b0);
    add_beat(MODE_TEXT, 8'h00, 1'b0);

    while (stim_count < 1600) begin
      if ($urandom_range(0, 99) < 85)
        add_pattern_session();
      else
        repeat ($urandom_range(1, 6))
          add_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(pending_beats.size() == 0 && !in_tvalid && results_seen >= beats_sent));
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, verdicts.size());
      err_count++;
    end
    $display("Sent %0d beats over loads, text starts, text bytes and the unused kind;",
             beats_sent);
    $display("checked %0d results: %0d full matches, %0d bytes dropped on a full store.",
             results_seen, hit_count, drop_count);
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rdsm_pkg.sv
design/rdsm_ram.sv
design/rdsm_ctrl.sv
design/rdsm_dp.sv
design/regex_dot_star_matcher_core.sv
tb/sv/testbench.sv
